// ===== rtl/blrl_pkg.sv =====
// Types and codes shared by the resolving list table, its slot cell and its checker.
// No dependencies.
`timescale 1ns / 1ps

package blrl_pkg;

    localparam int KEY_W = 56;

    typedef enum logic [2:0] {
        ACT_ADD      = 3'd0,
        ACT_REMOVE   = 3'd1,
        ACT_CLEAR    = 3'd2,
        ACT_SET_MODE = 3'd3,
        ACT_SET_EN   = 3'd4,
        ACT_RESET    = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_DISALLOWED = 3'd1,
        ST_INVALID    = 3'd2,
        ST_FULL       = 3'd3,
        ST_NOT_FOUND  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_LOOKUP = 2'd1,
        S_APPLY  = 2'd2
    } state_t;

    typedef enum logic [2:0] {
        CELL_NONE     = 3'd0,
        CELL_WRITE    = 3'd1,
        CELL_SHIFT    = 3'd2,
        CELL_SET_MODE = 3'd3,
        CELL_CLEAR    = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [KEY_W-1:0]   key;
        logic               mode;
    } cell_cmd_t;

    typedef struct packed {
        logic [2:0]  action;
        logic        advertising_active;
        logic [7:0]  identity_type;
        logic [47:0] identity_address;
        logic [7:0]  setting_value;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] entry_count;
        logic       resolution_enabled;
        logic [3:0] privacy_mode_bits;
    } rsp_t;

endpackage

// ===== rtl/blrl_cell.sv =====
// One slot of the resolving list: identity key, privacy-mode bit, registered key match.
// Depends on blrl_pkg.
`timescale 1ns / 1ps

module blrl_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  blrl_pkg::cell_cmd_t             cmd,
    input  logic                            occupied,
    input  logic                            tail,
    input  logic [blrl_pkg::KEY_W-1:0]      nbr_key,
    input  logic                            nbr_mode,
    input  logic                            shift_in,
    output logic [blrl_pkg::KEY_W-1:0]      key,
    output logic                            mode,
    output logic                            hit,
    output logic                            shift_out
);

    logic [blrl_pkg::KEY_W-1:0] key_reg, key_next;
    logic                       mode_reg, mode_next;
    logic                       hit_reg, hit_next;

    assign shift_out = shift_in | hit_reg;
    assign key       = key_reg;
    assign mode      = mode_reg;
    assign hit       = hit_reg;

    always_comb
    begin
        key_next  = key_reg;
        mode_next = mode_reg;
        hit_next  = occupied && (key_reg == cmd.key);
        case (cmd.op)
            blrl_pkg::CELL_WRITE:
            begin
                if (tail)
                begin
                    key_next = cmd.key;
                end
            end
            blrl_pkg::CELL_SHIFT:
            begin
                // slots at and above the removed one pull from the next slot up
                if (shift_out)
                begin
                    key_next  = nbr_key;
                    mode_next = nbr_mode;
                end
            end
            blrl_pkg::CELL_SET_MODE:
            begin
                if (hit_reg)
                begin
                    mode_next = cmd.mode;
                end
            end
            blrl_pkg::CELL_CLEAR:
            begin
                mode_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            hit_reg  <= hit_next;
        end
    end

endmodule

// ===== rtl/ble_resolving_list_table.sv =====
// Resolving list table: a row of blrl_cell slots kept compacted from slot 0, plus the
// command sequencer. Depends on blrl_pkg and blrl_cell.
//
// Each request is handled in steps, and the next request is taken only after it commits:
// one step to capture it, one in which every slot compares its stored
// identity with the request's key in parallel and registers the match, and one to commit
// the action and load the response. A waiting response holds off the commit step, and no
// new request is accepted meanwhile. The response shows the table state after its
// action. A remove shifts the later slots down by one through the neighbor links of the row.
`timescale 1ns / 1ps

module ble_resolving_list_table #(
    parameter int TABLE_CAPACITY = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  blrl_pkg::req_t   req_data,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output blrl_pkg::rsp_t   rsp_data
);

    localparam int CW = $clog2(TABLE_CAPACITY + 1);

    blrl_pkg::state_t             state_reg, state_next;
    blrl_pkg::req_t               req_reg, req_next;
    logic [CW-1:0]                count_reg, count_next;
    logic                         resen_reg, resen_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    logic [2:0]                   status_reg, status_next;
    blrl_pkg::cell_cmd_t          cmd;

    logic [blrl_pkg::KEY_W-1:0]   cell_key  [TABLE_CAPACITY];
    logic [TABLE_CAPACITY-1:0]    cell_mode;
    logic [TABLE_CAPACITY-1:0]    cell_hit;
    logic [TABLE_CAPACITY:0]      shift_chain;
    logic [TABLE_CAPACITY-1:0]    occupied;
    logic [TABLE_CAPACITY-1:0]    tail;

    logic                         locked;
    logic                         any_hit;
    logic                         full;
    logic                         commit;
    logic [CW+2:0]                count_ext;
    logic [TABLE_CAPACITY+3:0]    mode_ext;

    assign shift_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < TABLE_CAPACITY; g++)
        begin : g_slot
            logic [blrl_pkg::KEY_W-1:0] nbr_key;
            logic                       nbr_mode;

            assign occupied[g] = count_reg > CW'(g);
            assign tail[g]     = count_reg == CW'(g);

            if (g == TABLE_CAPACITY - 1)
            begin : g_last
                assign nbr_key  = cell_key[g];
                assign nbr_mode = 1'b0;
            end
            else
            begin : g_mid
                assign nbr_key  = cell_key[g+1];
                assign nbr_mode = cell_mode[g+1];
            end

            blrl_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .occupied  (occupied[g]),
                .tail      (tail[g]),
                .nbr_key   (nbr_key),
                .nbr_mode  (nbr_mode),
                .shift_in  (shift_chain[g]),
                .key       (cell_key[g]),
                .mode      (cell_mode[g]),
                .hit       (cell_hit[g]),
                .shift_out (shift_chain[g+1])
            );
        end
    endgenerate

    assign locked  = resen_reg && req_reg.advertising_active;
    assign any_hit = |cell_hit;
    assign full    = count_reg == CW'(TABLE_CAPACITY);
    assign commit  = (state_reg == blrl_pkg::S_APPLY) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        resen_next     = resen_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        cmd.op         = blrl_pkg::CELL_NONE;
        cmd.key        = {req_reg.identity_type, req_reg.identity_address};
        cmd.mode       = req_reg.setting_value[0];

        case (state_reg)
            blrl_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next   = req_data;
                    state_next = blrl_pkg::S_LOOKUP;
                end
            end
            blrl_pkg::S_LOOKUP:
            begin
                state_next = blrl_pkg::S_APPLY;
            end
            blrl_pkg::S_APPLY:
            begin
                if (commit)
                begin
                    state_next     = blrl_pkg::S_IDLE;
                    rsp_valid_next = 1'b1;
                    status_next    = blrl_pkg::ST_OK;
                    case (req_reg.action)
                        blrl_pkg::ACT_ADD:
                        begin
                            if (locked)
                                status_next = blrl_pkg::ST_DISALLOWED;
                            else if (req_reg.identity_type > 8'd1)
                                status_next = blrl_pkg::ST_INVALID;
                            else if (any_hit)
                                status_next = blrl_pkg::ST_INVALID;
                            else if (full)
                                status_next = blrl_pkg::ST_FULL;
                            else
                            begin
                                cmd.op     = blrl_pkg::CELL_WRITE;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        blrl_pkg::ACT_REMOVE:
                        begin
                            if (locked)
                                status_next = blrl_pkg::ST_DISALLOWED;
                            else if (!any_hit)
                                status_next = blrl_pkg::ST_NOT_FOUND;
                            else
                            begin
                                cmd.op     = blrl_pkg::CELL_SHIFT;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        blrl_pkg::ACT_CLEAR:
                        begin
                            if (locked)
                                status_next = blrl_pkg::ST_DISALLOWED;
                            else
                            begin
                                cmd.op     = blrl_pkg::CELL_CLEAR;
                                count_next = '0;
                            end
                        end
                        blrl_pkg::ACT_SET_MODE:
                        begin
                            if (req_reg.identity_type > 8'd1 || req_reg.setting_value > 8'd1)
                                status_next = blrl_pkg::ST_INVALID;
                            else if (!any_hit)
                                status_next = blrl_pkg::ST_NOT_FOUND;
                            else
                                cmd.op = blrl_pkg::CELL_SET_MODE;
                        end
                        blrl_pkg::ACT_SET_EN:
                        begin
                            if (req_reg.advertising_active)
                                status_next = blrl_pkg::ST_DISALLOWED;
                            else if (req_reg.setting_value > 8'd1)
                                status_next = blrl_pkg::ST_INVALID;
                            else
                                resen_next = req_reg.setting_value[0];
                        end
                        blrl_pkg::ACT_RESET:
                        begin
                            cmd.op     = blrl_pkg::CELL_CLEAR;
                            count_next = '0;
                            resen_next = 1'b0;
                        end
                        default:
                        begin
                            status_next = blrl_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = blrl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blrl_pkg::S_IDLE;
            count_reg     <= '0;
            resen_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            resen_reg     <= resen_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        status_reg <= status_next;
    end

    // table state only changes on commit, which waits for the response slot to free up
    assign count_ext = (CW+3)'(count_reg);
    assign mode_ext  = {4'b0000, cell_mode};

    assign rsp_valid                    = rsp_valid_reg;
    assign rsp_data.status              = status_reg;
    assign rsp_data.entry_count         = count_ext[2:0];
    assign rsp_data.resolution_enabled  = resen_reg;
    assign rsp_data.privacy_mode_bits   = mode_ext[3:0];

endmodule

// ===== rtl/blrl_checker.sv =====
// Port-level checks for the resolving list table, bound to the top level.
// Depends on blrl_pkg and ble_resolving_list_table.
`timescale 1ns / 1ps

module blrl_checker #(
    parameter int TABLE_CAPACITY = 4
) (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input blrl_pkg::rsp_t   rsp_data
);

    localparam bit SMALL = TABLE_CAPACITY < 8;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in progress");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.status <= blrl_pkg::ST_NOT_FOUND)
        else $error("undefined status code");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && SMALL |-> rsp_data.entry_count <= 3'(TABLE_CAPACITY))
        else $error("entry count above capacity");

    a_mode_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && SMALL |-> (rsp_data.privacy_mode_bits >> rsp_data.entry_count) == 4'd0)
        else $error("privacy mode set on an empty slot");

endmodule

bind ble_resolving_list_table blrl_checker #(
    .TABLE_CAPACITY (TABLE_CAPACITY)
) u_blrl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);
